// File: design/lbp_pkg.sv
// Package with the shared types, register codes and the uniform class table.
`timescale 1ns / 1ps
`default_nettype none
package lbp_pkg;

  localparam int PIX_W  = 8;
  localparam int CODE_W = 8;
  localparam int IMGW_W = 11;
  localparam int IMGH_W = 12;
  localparam int CFG_W  = 12;

  localparam logic [IMGW_W-1:0] WIDTH_RESET  = IMGW_W'(640);
  localparam logic [IMGH_W-1:0] HEIGHT_RESET = IMGH_W'(480);
  localparam logic [IMGW_W-1:0] MIN_WIDTH    = IMGW_W'(3);
  localparam logic [IMGH_W-1:0] MIN_HEIGHT   = IMGH_W'(3);

  // Class given to every code with more than two circular transitions.
  localparam logic [CODE_W-1:0] NON_UNIFORM_CLASS = CODE_W'(58);

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_UNIFORM_MODE = 2'd2
  } cfg_index_t;

  typedef logic [255:0][CODE_W-1:0] uniform_lut_t;

  // Controls from the top level to the window unit.
  typedef struct packed {
    logic shift;
    logic uniform;
  } lbp_win_ctl_t;

  function automatic logic is_uniform_code(input logic [7:0] c);
    logic [7:0] t;
    int n;
    t = c ^ {c[6:0], c[7]};
    n = 0;
    for (int i = 0; i < 8; i++) begin
      n = n + int'(t[i]);
    end
    return n <= 2;
  endfunction

  // Uniform codes are numbered in increasing code order.
  function automatic uniform_lut_t build_uniform_lut();
    uniform_lut_t lut;
    int idx;
    idx = 0;
    for (int c = 0; c < 256; c++) begin
      if (is_uniform_code(8'(c))) begin
        lut[c] = CODE_W'(idx);
        idx = idx + 1;
      end else begin
        lut[c] = NON_UNIFORM_CLASS;
      end
    end
    return lut;
  endfunction

  localparam uniform_lut_t UNIFORM_LUT = build_uniform_lut();

endpackage
`default_nettype wire

// File: design/lbp_code_3x3_core.sv
// Top level of the 3x3 local binary pattern core.
`timescale 1ns / 1ps
`default_nettype none
// Takes one 8-bit grey pixel per word in raster order and returns one 8-bit LBP
// code per interior pixel (not in the first or last row or column), in raster
// order, with tlast on the last code of the frame. Border codes are not sent.
// The core accepts one pixel every clock unless the output stalls. The line
// store read is registered with the pixel that completes a window, then the
// comparisons and class lookup enter the output register. Both line stores
// are read once per pixel at the current column and written once per pixel.
// Write the image size and mode registers only while no pixels are in flight.
module lbp_code_3x3_core
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_index,
  input  wire  [CFG_W-1:0]    cfg_wdata,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [7:0]          in_tdata,     // [7:0] pixel
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [7:0]          out_tdata,    // [7:0] code
  output logic                out_tlast
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EWR  = $clog2(MAX_WIDTH + 1);
  localparam int EW   = (EWR > IMGW_W) ? EWR : IMGW_W;

  logic [IMGW_W-1:0] image_width_r;
  logic [IMGH_W-1:0] image_height_r;
  logic              uniform_mode_r;

  logic [CW-1:0]     col_r, col_nxt;
  logic [IMGH_W-1:0] row_r, row_nxt;
  logic [EW-1:0]     w_eff;
  logic [IMGH_W-1:0] h_eff;

  logic              s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [CW-1:0]     s1_col_r;
  logic              s1_int_r;
  logic              s1_last_r;
  logic              s1_adv;
  logic              accept;

  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_code_r;
  logic              out_last_r;

  logic [PIX_W-1:0]  top_rd, mid_rd;
  logic [CODE_W-1:0] code;
  lbp_win_ctl_t      win_ctl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
      uniform_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[IMGW_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[IMGH_W-1:0];
        CFG_UNIFORM_MODE: uniform_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width_r < MIN_WIDTH) begin
      w_eff = EW'(MIN_WIDTH);
    end else if (EW'(image_width_r) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width_r);
    end
    h_eff = (image_height_r < MIN_HEIGHT) ? MIN_HEIGHT : image_height_r;
  end

  // Handshake and pipeline control.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  // Stream position; a counter past a newly shortened dimension wraps at once.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (EW'(col_r) + EW'(1) >= w_eff) begin
        col_nxt = '0;
        if ({1'b0, row_r} + 13'd1 >= {1'b0, h_eff}) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + IMGH_W'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_int_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_tdata;
      s1_col_r  <= col_r;
      s1_int_r  <= (row_r >= IMGH_W'(2)) && (col_r >= CW'(2));
      s1_last_r <= (row_r == h_eff - IMGH_W'(1)) && (EW'(col_r) == w_eff - EW'(1));
    end
    if (s1_adv && s1_int_r) begin
      out_code_r <= code;
      out_last_r <= s1_last_r;
    end
  end

  lbp_line_store #(
    .Depth(MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (col_r),
    .wr_en    (s1_adv),
    .wr_addr  (s1_col_r),
    .wr_upper (mid_rd),
    .wr_middle(s1_pix_r),
    .top_r    (top_rd),
    .mid_r    (mid_rd)
  );

  assign win_ctl = '{shift: s1_adv, uniform: uniform_mode_r};

  lbp_window u_window (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (win_ctl),
    .top  (top_rd),
    .mid  (mid_rd),
    .bot  (s1_pix_r),
    .code (code)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(MAX_WIDTH - 1))
    else $error("column counter beyond line store depth");

  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    accept && s1_adv |-> col_r != s1_col_r)
    else $error("line store read and write hit the same entry");

  a_interior_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_int_r |=> out_valid_r)
    else $error("interior word not placed in output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

  a_uniform_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && uniform_mode_r |-> out_code_r <= NON_UNIFORM_CLASS)
    else $error("uniform class out of range");
`endif

endmodule
`default_nettype wire

// File: design/lbp_line_store.sv
// Two line stores holding the previous two image rows, with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lbp_line_store
  import lbp_pkg::*;
#(
  parameter int Depth = 1024
) (
  input  wire                      clk,
  input  wire                      rd_en,
  input  wire  [$clog2(Depth)-1:0] rd_addr,
  input  wire                      wr_en,
  input  wire  [$clog2(Depth)-1:0] wr_addr,
  input  wire  [PIX_W-1:0]         wr_upper,
  input  wire  [PIX_W-1:0]         wr_middle,
  output logic [PIX_W-1:0]         top_r,
  output logic [PIX_W-1:0]         mid_r
);

  logic [PIX_W-1:0] upper_mem [Depth];
  logic [PIX_W-1:0] middle_mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_r <= upper_mem[rd_addr];
      mid_r <= middle_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: design/lbp_window.sv
// The 3x3 window registers, the neighbour comparisons and the uniform mapping.
`timescale 1ns / 1ps
`default_nettype none
module lbp_window
  import lbp_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire lbp_win_ctl_t  ctl,
  input  wire  [PIX_W-1:0]   top,
  input  wire  [PIX_W-1:0]   mid,
  input  wire  [PIX_W-1:0]   bot,
  output logic [CODE_W-1:0]  code
);

  // Entries 0..2 are the left column, 3..5 the centre column (top to bottom).
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] ctr;
  logic [7:0]       raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (ctl.shift) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= bot;
    end
  end

  always_comb begin
    ctr    = win_r[4];
    raw[7] = win_r[3] > ctr;
    raw[6] = win_r[0] > ctr;
    raw[5] = win_r[1] > ctr;
    raw[4] = win_r[2] > ctr;
    raw[3] = win_r[5] > ctr;
    raw[2] = bot > ctr;
    raw[1] = mid > ctr;
    raw[0] = top > ctr;
    code   = ctl.uniform ? UNIFORM_LUT[raw] : raw;
  end

endmodule
`default_nettype wire
